FILE: src/graph_transitive_closure_defines.svh
// Assertion macros shared by the checker of the transitive closure block.
`ifndef GRAPH_TRANSITIVE_CLOSURE_DEFINES_SVH
`define GRAPH_TRANSITIVE_CLOSURE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtc assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtc assertion failed");

`endif

FILE: src/gtc_pkg.sv
// Shared constants and types of the transitive closure block.
`default_nettype none
package gtc_pkg;

  localparam int unsigned ROW_W         = 16;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned MAX_NODES_DEF = 16;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;

  // Request from the sequencer to the reach store.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ROW_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

FILE: src/gtc_in_if.sv
// Input channel: one adjacency row per item.
`default_nettype none
interface gtc_in_if
  import gtc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] node_index;
  logic [ROW_W-1:0] children_mask;
  logic             end_of_graph;

  modport source (output valid, node_index, children_mask, end_of_graph, input ready);
  modport sink   (input valid, node_index, children_mask, end_of_graph, output ready);
endinterface
`default_nettype wire

FILE: src/gtc_out_if.sv
// Result channel: one reachability row per item.
`default_nettype none
interface gtc_out_if
  import gtc_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] row_index;
  logic [ROW_W-1:0] reach_mask;
  logic             last_row;

  modport source (output valid, row_index, reach_mask, last_row, input ready);
  modport sink   (input valid, row_index, reach_mask, last_row, output ready);
endinterface
`default_nettype wire

FILE: src/gtc_reach_mem.sv
// Reach store: one write port, one registered read port with write bypass.
`default_nettype none
module gtc_reach_mem
  import gtc_pkg::*;
#(
  parameter int unsigned ROWS = MAX_NODES_DEF
) (
  input  wire logic             clk,
  input  wire mem_req_t         req,
  output logic [ROW_W-1:0]      rd_data
);

  localparam int unsigned IW = $clog2(ROWS);

  logic [ROW_W-1:0] mem_r [ROWS];
  logic [ROW_W-1:0] mem_q_r;
  logic [ROW_W-1:0] byp_data_r;
  logic             byp_hit_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr[IW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      mem_q_r <= mem_r[req.raddr[IW-1:0]];
    end
  end

  // Forward a row written in the same cycle it is read.
  always_ff @(posedge clk) begin
    if (req.re) begin
      byp_hit_r  <= req.we && (req.waddr == req.raddr);
      byp_data_r <= req.wdata;
    end
  end

  assign rd_data = byp_hit_r ? byp_data_r : mem_q_r;

endmodule
`default_nettype wire

FILE: src/gtc_ctrl.sv
// Sequencer: adjacency rows, Warshall sweep over the reach store, output register.
`default_nettype none
module gtc_ctrl
  import gtc_pkg::*;
#(
  parameter int unsigned ROWS = MAX_NODES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [IDX_W-1:0] in_node_index,
  input  wire logic [ROW_W-1:0] in_children_mask,
  input  wire logic             in_end_of_graph,
  input  wire logic [CNT_W-1:0] node_count,
  output mem_req_t              mem_req,
  input  wire logic [ROW_W-1:0] rd_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [IDX_W-1:0]      out_row_index,
  output logic [ROW_W-1:0]      out_reach_mask,
  output logic                  out_last_row
);

  localparam int unsigned IW = $clog2(ROWS);
  localparam int unsigned NW = $clog2(ROWS + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INIT   = 6'b000010,
    S_PIVOT  = 6'b000100,
    S_SWEEP  = 6'b001000,
    S_OUT_RD = 6'b010000,
    S_OUT_LD = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [NW-1:0]    n_r, idx_r, k_r;
  logic [ROW_W-1:0] adj_r [ROWS];
  logic [ROW_W-1:0] pivot_r;
  logic             rd_pivot_r, rd_row_r;
  logic [IDX_W-1:0] kd_r, rd_addr_r;
  logic             out_valid_r, out_last_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [ROW_W-1:0] out_row_r;

  logic [NW-1:0]    eff_n, n_last;
  logic             last_idx, last_k, accept, store_row, adj_clr, ret_hit;
  logic [IDX_W-1:0] idx4, k4;
  logic [ROW_W-1:0] cols;

  always_comb begin
    if (node_count > CNT_W'(ROWS)) begin
      eff_n = NW'(ROWS);
    end else begin
      eff_n = node_count[NW-1:0];
    end
  end

  assign n_last   = NW'(n_r - NW'(1));
  assign last_idx = (idx_r == n_last);
  assign last_k   = (k_r == n_last);
  assign idx4     = IDX_W'(idx_r[IW-1:0]);
  assign k4       = IDX_W'(k_r[IW-1:0]);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign store_row = accept && ({1'b0, in_node_index} < CNT_W'(ROWS));
  assign adj_clr  = ((state_r == S_INIT) && last_idx) ||
                    (accept && in_end_of_graph && (eff_n == '0));
  assign ret_hit  = rd_row_r && rd_data[kd_r];

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      cols[j] = (CNT_W'(j) < CNT_W'(n_r));
    end
  end

  // Adjacency rows, cleared once the closure has taken them in.
  always_ff @(posedge clk) begin
    if (!rst_n || adj_clr) begin
      for (int r = 0; r < ROWS; r++) begin
        adj_r[r] <= '0;
      end
    end else if (store_row) begin
      adj_r[in_node_index[IW-1:0]] <= in_children_mask;
    end
  end

  always_comb begin
    mem_req = '0;
    if (state_r == S_INIT) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = idx4;
      mem_req.wdata = (adj_r[idx_r[IW-1:0]] & cols) | (ROW_W'(1) << idx4);
    end
    // Row i picks up the pivot row when it reaches node k.
    if (ret_hit) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = rd_addr_r;
      mem_req.wdata = rd_data | pivot_r;
    end
    if (state_r == S_PIVOT) begin
      mem_req.re    = 1'b1;
      mem_req.raddr = k4;
    end else if (state_r == S_SWEEP ||
                 (state_r == S_OUT_RD && !out_valid_r)) begin
      mem_req.re    = 1'b1;
      mem_req.raddr = idx4;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_end_of_graph && (eff_n != '0)) state_nxt = S_INIT;
      end
      S_INIT: begin
        if (last_idx) state_nxt = S_PIVOT;
      end
      S_PIVOT: state_nxt = S_SWEEP;
      S_SWEEP: begin
        if (last_idx) state_nxt = last_k ? S_OUT_RD : S_PIVOT;
      end
      S_OUT_RD: begin
        if (!out_valid_r) state_nxt = S_OUT_LD;
      end
      S_OUT_LD: state_nxt = last_idx ? S_IDLE : S_OUT_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= '0;
      idx_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_end_of_graph) begin
            n_r   <= eff_n;
            idx_r <= '0;
          end
        end
        S_INIT: begin
          if (last_idx) begin
            idx_r <= '0;
            k_r   <= '0;
          end else begin
            idx_r <= NW'(idx_r + NW'(1));
          end
        end
        S_PIVOT: ;
        S_SWEEP: begin
          if (last_idx) begin
            idx_r <= '0;
            if (!last_k) k_r <= NW'(k_r + NW'(1));
          end else begin
            idx_r <= NW'(idx_r + NW'(1));
          end
        end
        S_OUT_RD: ;
        S_OUT_LD: begin
          if (!last_idx) idx_r <= NW'(idx_r + NW'(1));
        end
        default: ;
      endcase
    end
  end

  // Tag each pivot and sweep read so its data is handled in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pivot_r <= 1'b0;
      rd_row_r   <= 1'b0;
    end else begin
      rd_pivot_r <= (state_r == S_PIVOT);
      rd_row_r   <= (state_r == S_SWEEP);
    end
  end

  always_ff @(posedge clk) begin
    kd_r      <= k4;
    rd_addr_r <= idx4;
    if (rd_pivot_r) pivot_r <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT_LD) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT_LD) begin
      out_row_r  <= rd_data;
      out_idx_r  <= idx4;
      out_last_r <= last_idx;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_index  = out_idx_r;
  assign out_reach_mask = out_row_r;
  assign out_last_row   = out_last_r;

endmodule
`default_nettype wire

FILE: src/graph_transitive_closure.sv
// Reflexive transitive closure of a directed graph of up to 16 nodes. Rows of
// the adjacency matrix are taken one per cycle while idle; the item with
// end_of_graph set starts the closure, and the block stays busy until the last
// reachability row has been loaded into the output register. With n the node
// count in force (node_count clipped to MAX_NODES and 16) the closure seeds the
// reach store, then makes n passes (one pivot read, then one row read per
// cycle), then reads and loads each emitted row once the row before it has been
// taken, the pace set by the single read port of the reach store. A zero node
// count emits nothing and only clears the adjacency rows.
`default_nettype none
module graph_transitive_closure
  import gtc_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  gtc_in_if.sink                in_if,
  gtc_out_if.source             out_if,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam int unsigned ROWS = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;

  logic [CNT_W-1:0] node_count_r;
  mem_req_t         mem_req;
  logic [ROW_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  gtc_ctrl #(.ROWS(ROWS)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_if.valid),
    .in_ready         (in_if.ready),
    .in_node_index    (in_if.node_index),
    .in_children_mask (in_if.children_mask),
    .in_end_of_graph  (in_if.end_of_graph),
    .node_count       (node_count_r),
    .mem_req          (mem_req),
    .rd_data          (rd_data),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_row_index    (out_if.row_index),
    .out_reach_mask   (out_if.reach_mask),
    .out_last_row     (out_if.last_row)
  );

  gtc_reach_mem #(.ROWS(ROWS)) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

FILE: src/gtc_checker.sv
// Port-level checker of the transitive closure block and its bind.
`default_nettype none
`include "graph_transitive_closure_defines.svh"
module gtc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_end_of_graph,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last_row
);

  // Hold a result that has not been taken.
  `GTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // A row that is not the end of a graph leaves the block ready.
  `GTC_ASSERT_NEXT(a_row_keeps_ready, in_valid && in_ready && !in_end_of_graph, in_ready)
  // No new item while rows of a graph are still to come.
  `GTC_ASSERT_NOW(a_busy_while_emit, out_valid && !out_last_row, !in_ready)
  `GTC_ASSERT_NEXT(a_busy_after_row, out_valid && out_ready && !out_last_row, !in_ready)

endmodule

bind graph_transitive_closure gtc_checker u_gtc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .in_end_of_graph (in_if.end_of_graph),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_last_row    (out_if.last_row)
);
`default_nettype wire

FILE: test/tb_graph_transitive_closure.sv
// Testbench for graph_transitive_closure: directed and random graphs, Warshall predictor.
module tb_graph_transitive_closure
  import gtc_pkg::*;
  ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROWS = MAX_NODES_DEF;
  localparam int RANDOM_ITEMS = 400;
  // Idle wait covering the worst closure at n = 16, plus margin.
  localparam int SETTLE_CYCLES = MAX_ROWS * MAX_ROWS + 5 * MAX_ROWS + 32;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [ROW_W-1:0] reach;
    logic             last;
  } reach_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  bit               no_idle = 1'b0;
  int               mismatch_count = 0;

  logic [ROW_W-1:0] adjacency_model [MAX_ROWS];
  logic [CNT_W-1:0] node_count_q;
  reach_row_t       pending_rows [$];

  gtc_in_if  in_ch ();
  gtc_out_if out_ch ();

  graph_transitive_closure dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 35);
  end

  // Store one adjacency row; on end of graph run the closure and queue its rows.
  function automatic void absorb_row(input logic [IDX_W-1:0] idx,
                                     input logic [ROW_W-1:0] kids, input logic eog);
    logic [ROW_W-1:0] reach [MAX_ROWS];
    logic [ROW_W-1:0] cols;
    int n;
    reach_row_t exp_row;
    adjacency_model[idx] = kids;
    if (!eog) return;
    n = (node_count_q > MAX_ROWS) ? MAX_ROWS : int'(node_count_q);
    cols = '0;
    for (int i = 0; i < n; i++) cols[i] = 1'b1;
    for (int i = 0; i < n; i++) begin
      reach[i] = adjacency_model[i] & cols;
      reach[i][i] = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        if (reach[i][k]) reach[i] = reach[i] | reach[k];
      end
    end
    for (int s = 0; s < n; s++) begin
      exp_row.row   = s[IDX_W-1:0];
      exp_row.reach = reach[s];
      exp_row.last  = (s == n - 1);
      pending_rows = {pending_rows, exp_row};
    end
    foreach (adjacency_model[i]) adjacency_model[i] = '0;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item, valid still high.
  task automatic send_row(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] kids,
                          input logic eog);
    int gap;
    gap = 0;
    while (!no_idle && $urandom_range(99) < 35) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.node_index    <= idx;
    in_ch.children_mask <= kids;
    in_ch.end_of_graph  <= eog;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_row(idx, kids, eog);
  endtask

  // Drain all rows and let the block go idle before touching the register.
  task automatic set_node_count(input logic [CNT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count_q = value;
  endtask

  task automatic test_default_count();
    send_row(4'd0, 16'h0002, 1'b0);
    send_row(4'd1, 16'h8000, 1'b0);
    send_row(4'd3, 16'h0001, 1'b0);
    // later row for node 3 replaces the earlier one
    send_row(4'd3, 16'h0010, 1'b0);
    send_row(4'd4, 16'h0000, 1'b0);
    send_row(4'd15, 16'hFFFF, 1'b1);
  endtask

  task automatic test_count_limits();
    set_node_count(5'd1);
    send_row(4'd0, 16'hFFFF, 1'b1);
    // zero nodes: nothing emitted, rows still cleared
    set_node_count(5'd0);
    send_row(4'd5, 16'h1234, 1'b0);
    send_row(4'd0, 16'h0021, 1'b1);
    set_node_count(5'd16);
    send_row(4'd9, 16'h0000, 1'b1);
    // counts above the node limit saturate
    set_node_count(5'd17);
    send_row(4'd14, 16'h8000, 1'b1);
    set_node_count(5'd31);
    send_row(4'd15, 16'h4000, 1'b0);
    send_row(4'd14, 16'hAAAA, 1'b1);
  endtask

  task automatic test_masked_children();
    set_node_count(5'd4);
    send_row(4'd0, 16'hFFF2, 1'b0);
    send_row(4'd1, 16'h0008, 1'b0);
    send_row(4'd3, 16'h0001, 1'b0);
    // row beyond the node count is stored but ignored
    send_row(4'd9, 16'h000F, 1'b0);
    send_row(4'd2, 16'h8004, 1'b1);
  endtask

  task automatic test_random_graphs();
    int sent;
    int len;
    int n_eff;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] kids;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = (sent >= 150 && sent < 250);
      if ($urandom_range(9) < 4) begin
        case ($urandom_range(9))
          0:       count = 5'd0;
          1:       count = 5'($urandom_range(31, 17));
          2:       count = 5'd16;
          default: count = 5'($urandom_range(16, 1));
        endcase
        set_node_count(count);
      end
      n_eff = (node_count_q > MAX_ROWS) ? MAX_ROWS : int'(node_count_q);
      len = $urandom_range(20, 1);
      for (int j = 0; j < len; j++) begin
        if (n_eff == 0 || $urandom_range(3) == 0) idx = 4'($urandom_range(15));
        else idx = 4'($urandom_range(n_eff - 1));
        case ($urandom_range(3))
          0:       kids = 16'($urandom & $urandom & $urandom);
          1:       kids = 16'd1 << $urandom_range(15);
          2:       kids = 16'($urandom);
          default: kids = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
        send_row(idx, kids, j == len - 1);
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin : check_result
    reach_row_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_rows.size() == 0) begin
        $error("unexpected result row_index %0d reach_mask %h", out_ch.row_index,
               out_ch.reach_mask);
        mismatch_count++;
      end else begin
        want = pending_rows.pop_front();
        if (out_ch.row_index !== want.row) begin
          $error("row_index expected %0d got %0d", want.row, out_ch.row_index);
          mismatch_count++;
        end
        if (out_ch.reach_mask !== want.reach) begin
          $error("reach_mask expected %h got %h", want.reach, out_ch.reach_mask);
          mismatch_count++;
        end
        if (out_ch.last_row !== want.last) begin
          $error("last_row expected %0b got %0b", want.last, out_ch.last_row);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.node_index    = '0;
    in_ch.children_mask = '0;
    in_ch.end_of_graph  = 1'b0;
    out_ch.ready        = 1'b0;
    node_count_q        = NODE_COUNT_RST;
    foreach (adjacency_model[i]) adjacency_model[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_default_count();
    test_count_limits();
    test_masked_children();
    test_random_graphs();

    in_ch.valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_rows.size() == 0) begin
      $display("PASS graph_transitive_closure");
    end else begin
      $display("FAIL graph_transitive_closure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL graph_transitive_closure");
    $finish;
  end

endmodule

FILE: graph_transitive_closure.f
+incdir+src
src/gtc_pkg.sv
src/gtc_in_if.sv
src/gtc_out_if.sv
src/gtc_reach_mem.sv
src/gtc_ctrl.sv
src/graph_transitive_closure.sv
src/gtc_checker.sv
test/tb_graph_transitive_closure.sv
